// ===== hdl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/blp_pkg.sv =====
package blp_pkg;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned COORD_MAX = 63;
  localparam int unsigned TWICE_W   = COORD_W + 1;
  localparam int unsigned ERR_W     = COORD_W + 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [TWICE_W-1:0] twice_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_req_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   is_last;
  } line_pt_t;

  // per-line constants that drive the step unit
  typedef struct packed {
    twice_t twice_dx;
    twice_t twice_dy;
    logic   x_dir_neg;
    logic   y_dir_neg;
    logic   x_is_major;
  } line_cfg_t;

  function automatic coord_t clamp_coord(coord_t v);
    coord_t r;
    r = (v > COORD_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) : v;
    return r;
  endfunction

  function automatic coord_t step_coord(coord_t c, logic neg);
    coord_t r;
    r = neg ? (c - COORD_W'(1)) : (c + COORD_W'(1));
    return r;
  endfunction

endpackage

// ===== hdl/bresenham_line_points.sv =====
// channel  | direction | payload    | handshake
// ---------+-----------+------------+----------------------
// req      | in        | line_req_t | req_valid / req_stall
// pt       | out       | line_pt_t  | pt_valid / pt_stall
//
// a line is latched with its set-up deltas when its request is taken, then
// walked one point per cycle while pt is not stalled, by the single step unit
// req_stall stays high while a line is walked, until its last point is taken
// a stalled pt beat holds its point and the walk waits
// rst is synchronous and active high; it returns the block to idle
`include "assert_macros.svh"

module bresenham_line_points (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  blp_pkg::line_req_t  req_data,
  output logic                pt_valid,
  input  logic                pt_stall,
  output blp_pkg::line_pt_t   pt_data
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t state;

  // current walk position and per-line constants
  blp_pkg::coord_t   cur_x;
  blp_pkg::coord_t   cur_y;
  blp_pkg::coord_t   goal_x;
  blp_pkg::coord_t   goal_y;
  blp_pkg::err_t     err_acc;
  blp_pkg::line_cfg_t cfg;

  // setup results for the beat on the input
  blp_pkg::coord_t   su_start_x;
  blp_pkg::coord_t   su_start_y;
  blp_pkg::coord_t   su_end_x;
  blp_pkg::coord_t   su_end_y;
  blp_pkg::line_cfg_t su_cfg;
  blp_pkg::err_t     su_err;

  // next point from the step unit
  blp_pkg::coord_t   cur_x_next;
  blp_pkg::coord_t   cur_y_next;
  blp_pkg::err_t     err_acc_next;

  logic req_take;
  logic pt_take;
  logic at_goal;

  blp_setup u_setup (
    .req      (req_data),
    .start_x  (su_start_x),
    .start_y  (su_start_y),
    .end_x    (su_end_x),
    .end_y    (su_end_y),
    .cfg      (su_cfg),
    .err_init (su_err)
  );

  blp_step u_step (
    .cfg        (cfg),
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .err        (err_acc),
    .cur_x_next (cur_x_next),
    .cur_y_next (cur_y_next),
    .err_next   (err_acc_next)
  );

  // the major coordinate only moves toward the goal, so the goal point is
  // reached exactly once, on the final point
  assign at_goal   = (cur_x == goal_x) && (cur_y == goal_y);

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign pt_valid  = (state == S_WALK);
  assign pt_take   = pt_valid && !pt_stall;

  assign pt_data.point_x = cur_x;
  assign pt_data.point_y = cur_y;
  assign pt_data.is_last = at_goal;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur_x   <= '0;
      cur_y   <= '0;
      goal_x  <= '0;
      goal_y  <= '0;
      cfg     <= '0;
      err_acc <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            // latch the line and its first point
            state   <= S_WALK;
            cur_x   <= su_start_x;
            cur_y   <= su_start_y;
            goal_x  <= su_end_x;
            goal_y  <= su_end_y;
            cfg     <= su_cfg;
            err_acc <= su_err;
          end
        end
        S_WALK: begin
          if (pt_take) begin
            if (at_goal) begin
              state <= S_IDLE;
            end else begin
              // advance one point per taken beat
              cur_x   <= cur_x_next;
              cur_y   <= cur_y_next;
              err_acc <= err_acc_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // first point of a line is its start point
  `ASSERT_NEXT(a_first_point, clk, rst, req_take,
    pt_valid && (pt_data.point_x == blp_pkg::clamp_coord($past(req_data.start_x)))
    && (pt_data.point_y == blp_pkg::clamp_coord($past(req_data.start_y))),
    "first point is not the start point")
  // taking the last point frees the block
  `ASSERT_NEXT(a_last_frees, clk, rst, pt_take && pt_data.is_last,
    !pt_valid && !req_stall, "block still busy after the last point")
  // taking an inner point keeps the walk going
  `ASSERT_NEXT(a_walk_goes_on, clk, rst, pt_take && !pt_data.is_last,
    pt_valid, "walk ended before the last point")
  // the walk never outruns the goal column when x is the major axis
  `ASSERT_SAME(a_major_bound, clk, rst, pt_valid && cfg.x_is_major,
    cfg.x_dir_neg ? (cur_x >= goal_x) : (cur_x <= goal_x),
    "walk passed the goal column")

endmodule

// ===== hdl/blp_setup.sv =====
module blp_setup (
  input  blp_pkg::line_req_t req,
  output blp_pkg::coord_t    start_x,
  output blp_pkg::coord_t    start_y,
  output blp_pkg::coord_t    end_x,
  output blp_pkg::coord_t    end_y,
  output blp_pkg::line_cfg_t cfg,
  output blp_pkg::err_t      err_init
);

  blp_pkg::coord_t adx;
  blp_pkg::coord_t ady;
  logic signed [blp_pkg::ERR_W:0] err_wide;

  assign start_x = blp_pkg::clamp_coord(req.start_x);
  assign start_y = blp_pkg::clamp_coord(req.start_y);
  assign end_x   = blp_pkg::clamp_coord(req.end_x);
  assign end_y   = blp_pkg::clamp_coord(req.end_y);

  always_comb begin
    cfg.x_dir_neg  = end_x < start_x;
    cfg.y_dir_neg  = end_y < start_y;
    adx            = cfg.x_dir_neg ? (start_x - end_x) : (end_x - start_x);
    ady            = cfg.y_dir_neg ? (start_y - end_y) : (end_y - start_y);
    cfg.twice_dx   = {adx, 1'b0};
    cfg.twice_dy   = {ady, 1'b0};
    cfg.x_is_major = cfg.twice_dx >= cfg.twice_dy;
    // doubled minor delta minus major delta
    if (cfg.x_is_major) begin
      err_wide = $signed({2'b00, cfg.twice_dy}) - $signed({3'b000, adx});
    end else begin
      err_wide = $signed({2'b00, cfg.twice_dx}) - $signed({3'b000, ady});
    end
    err_init = err_wide[blp_pkg::ERR_W-1:0];
  end

endmodule

// ===== hdl/blp_step.sv =====
module blp_step (
  input  blp_pkg::line_cfg_t cfg,
  input  blp_pkg::coord_t    cur_x,
  input  blp_pkg::coord_t    cur_y,
  input  blp_pkg::err_t      err,
  output blp_pkg::coord_t    cur_x_next,
  output blp_pkg::coord_t    cur_y_next,
  output blp_pkg::err_t      err_next
);

  logic minor_step;
  blp_pkg::twice_t add_term;
  blp_pkg::twice_t sub_term;
  logic signed [blp_pkg::ERR_W+1:0] sum;

  always_comb begin
    // minor axis moves when the error is positive
    minor_step = !err[blp_pkg::ERR_W-1] && (err != '0);
    add_term   = cfg.x_is_major ? cfg.twice_dy : cfg.twice_dx;
    sub_term   = minor_step ? (cfg.x_is_major ? cfg.twice_dx : cfg.twice_dy) : '0;
    sum        = (blp_pkg::ERR_W+2)'(err) + $signed({3'b000, add_term})
                 - $signed({3'b000, sub_term});
    err_next   = sum[blp_pkg::ERR_W-1:0];
    if (cfg.x_is_major) begin
      cur_x_next = blp_pkg::step_coord(cur_x, cfg.x_dir_neg);
      cur_y_next = minor_step ? blp_pkg::step_coord(cur_y, cfg.y_dir_neg) : cur_y;
    end else begin
      cur_y_next = blp_pkg::step_coord(cur_y, cfg.y_dir_neg);
      cur_x_next = minor_step ? blp_pkg::step_coord(cur_x, cfg.x_dir_neg) : cur_x;
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // longest pause the receiver forces while the sender keeps offering lines
  localparam int HOLD_CYCLES   = 300;
  // cycles without any beat before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  // settle time after the last point, before the final verdict
  localparam int TAIL_CYCLES   = 80;
  localparam int REPORT_LIMIT  = 10;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  blp_pkg::line_req_t req_data  = '0;
  logic               pt_valid;
  logic               pt_stall  = 1'b0;
  blp_pkg::line_pt_t  pt_data;

  // lines waiting to be offered, front is the one on the bus
  blp_pkg::line_req_t queued_lines[$];
  // points the walk must still produce, oldest first
  blp_pkg::line_pt_t  pending_points[$];

  int send_idle_pct = 38;
  int recv_idle_pct = 73;
  logic hold_go     = 1'b0;
  int hold_cnt      = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  bresenham_line_points DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt_data   (pt_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // coordinates above the grid edge are pinned to the edge
  function automatic blp_pkg::coord_t saturate(blp_pkg::coord_t v);
    return (v > blp_pkg::COORD_MAX) ? blp_pkg::coord_t'(blp_pkg::COORD_MAX) : v;
  endfunction

  // build a line request, clamping any coordinate onto the grid
  function automatic blp_pkg::line_req_t make_line(int sx, int sy, int ex, int ey);
    blp_pkg::line_req_t line;
    line.start_x = blp_pkg::coord_t'((sx < 0) ? 0 : (sx > 63) ? 63 : sx);
    line.start_y = blp_pkg::coord_t'((sy < 0) ? 0 : (sy > 63) ? 63 : sy);
    line.end_x   = blp_pkg::coord_t'((ex < 0) ? 0 : (ex > 63) ? 63 : ex);
    line.end_y   = blp_pkg::coord_t'((ey < 0) ? 0 : (ey > 63) ? 63 : ey);
    return line;
  endfunction

  // walk one line the bresenham way and queue every point it visits
  function automatic void walk_line(blp_pkg::line_req_t line);
    blp_pkg::coord_t   cx, cy, ex, ey;
    logic              x_neg, y_neg, x_major;
    int                adx, ady, tdx, tdy, major_len, err_acc, i;
    blp_pkg::line_pt_t pt;
    cx = saturate(line.start_x);
    cy = saturate(line.start_y);
    ex = saturate(line.end_x);
    ey = saturate(line.end_y);
    // a zero delta counts as a positive direction
    x_neg = ex < cx;
    y_neg = ey < cy;
    adx = x_neg ? int'(cx) - int'(ex) : int'(ex) - int'(cx);
    ady = y_neg ? int'(cy) - int'(ey) : int'(ey) - int'(cy);
    tdx = (adx * 2) & 'h7f;
    tdy = (ady * 2) & 'h7f;
    // x is major on a tie
    x_major   = tdx >= tdy;
    major_len = x_major ? adx : ady;
    err_acc   = x_major ? tdy - adx : tdx - ady;
    for (i = 0; i <= major_len; i++) begin
      pt.point_x = cx;
      pt.point_y = cy;
      pt.is_last = (i == major_len);
      pending_points.push_back(pt);
      if (x_major) begin
        if (err_acc > 0) begin
          cy = y_neg ? cy - 1'b1 : cy + 1'b1;
          err_acc -= tdx;
        end
        cx = x_neg ? cx - 1'b1 : cx + 1'b1;
        err_acc += tdy;
      end else begin
        if (err_acc > 0) begin
          cx = x_neg ? cx - 1'b1 : cx + 1'b1;
          err_acc -= tdy;
        end
        cy = y_neg ? cy - 1'b1 : cy + 1'b1;
        err_acc += tdx;
      end
    end
  endfunction

  // random lines: mostly free endpoints, plus short hops, axis lines and diagonals
  task automatic queue_random_lines(int count);
    int sx, sy, ex, ey, shape, reach, n;
    for (n = 0; n < count; n++) begin
      sx    = $urandom_range(63);
      sy    = $urandom_range(63);
      shape = $urandom_range(99);
      if (shape < 55) begin
        ex = $urandom_range(63);
        ey = $urandom_range(63);
      end else if (shape < 80) begin
        ex = sx + int'($urandom_range(8)) - 4;
        ey = sy + int'($urandom_range(8)) - 4;
      end else if (shape < 90) begin
        if ($urandom_range(1) == 1) begin
          ex = $urandom_range(63);
          ey = sy;
        end else begin
          ex = sx;
          ey = $urandom_range(63);
        end
      end else begin
        reach = $urandom_range(63);
        ex = ($urandom_range(1) == 1) ? sx + reach : sx - reach;
        ey = ($urandom_range(1) == 1) ? sy + reach : sy - reach;
      end
      queued_lines.push_back(make_line(sx, sy, ex, ey));
    end
  endtask

  // wait until every queued line is taken and every point has come back
  task automatic wait_for_drain();
    while (queued_lines.size() != 0 || pending_points.size() != 0)
      @(posedge clk);
  endtask

  // request driver: predict on the accepted beat, hold a stalled beat steady
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        walk_line(req_data);
        void'(queued_lines.pop_front());
      end
      if (!(req_valid && req_stall)) begin
        // a taken line is already popped, so the front is the next one
        if (queued_lines.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req_data  <= queued_lines[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // point receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      pt_stall <= 1'b0;
    end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      pt_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      pt_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // point checker: every taken beat must match the oldest predicted point
  always @(posedge clk) begin
    if (!rst && pt_valid && !pt_stall) begin
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected point beat: x=%0d y=%0d last=%0b",
                   pt_data.point_x, pt_data.point_y, pt_data.is_last);
      end else if (pt_data.point_x !== pending_points[0].point_x ||
                   pt_data.point_y !== pending_points[0].point_y ||
                   pt_data.is_last !== pending_points[0].is_last) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("point mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   pending_points[0].point_x, pending_points[0].point_y,
                   pending_points[0].is_last,
                   pt_data.point_x, pt_data.point_y, pt_data.is_last);
        void'(pending_points.pop_front());
      end else begin
        void'(pending_points.pop_front());
      end
    end
  end

  // watchdog: too long without a beat on either side means the block hung
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (pt_valid && !pt_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed lines: single point, corners, axes, ties, steep and shallow
    queued_lines.push_back(make_line( 0,  0,  0,  0));
    queued_lines.push_back(make_line(63, 63, 63, 63));
    queued_lines.push_back(make_line( 0,  0, 63, 63));
    queued_lines.push_back(make_line(63, 63,  0,  0));
    queued_lines.push_back(make_line( 0, 63, 63,  0));
    queued_lines.push_back(make_line(63,  0,  0, 63));
    queued_lines.push_back(make_line( 0,  0, 63,  0));
    queued_lines.push_back(make_line(63,  5,  0,  5));
    queued_lines.push_back(make_line( 7,  0,  7, 63));
    queued_lines.push_back(make_line( 7, 63,  7,  0));
    queued_lines.push_back(make_line( 0,  0, 63,  1));
    queued_lines.push_back(make_line( 0,  0,  1, 63));
    queued_lines.push_back(make_line(63,  0, 62, 63));
    queued_lines.push_back(make_line(10, 10, 20, 15));
    queued_lines.push_back(make_line(10, 10, 15, 20));
    queued_lines.push_back(make_line(20, 15, 10, 10));
    queued_lines.push_back(make_line(30, 30, 31, 30));
    queued_lines.push_back(make_line(30, 30, 30, 31));
    queued_lines.push_back(make_line( 5, 40,  6, 39));
    queued_lines.push_back(make_line(21, 42, 42, 21));
    queued_lines.push_back(make_line(42, 21, 21, 42));
    queue_random_lines(130);
    wait_for_drain();

    // swap the idle rates: slow sender, eager receiver
    @(posedge clk);
    send_idle_pct <= 73;
    recv_idle_pct <= 38;
    queue_random_lines(130);
    wait_for_drain();

    // full speed, opened by a long receiver hold-off while lines keep coming
    @(posedge clk);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_go       <= 1'b1;
    queue_random_lines(130);
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
